### hw/rtl/chsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel scan and keypad select: shared definitions
// Operation codes, controller states and field widths for the channel
// scan and keypad selection block.
// ----------------------------------------------------------------------------
package chsk_pkg;

   // Default number of channels in the in-use bitmap.
   localparam int NUM_CHANNELS_DEF = 1024;

   // Bitmap word geometry: one memory word holds this many in-use bits.
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   // Fixed field widths of the transaction payloads.
   localparam int CH_W    = 11;
   localparam int DIGIT_W = 4;
   localparam int OP_W    = 3;

   // Keypad arithmetic.
   localparam int DIGIT_MAX  = 9;
   localparam int DIGIT_BASE = 10;

   // Operation codes carried in the request tuser field.
   typedef enum logic [OP_W-1:0] {
      OP_MARK   = 3'd0,
      OP_INIT   = 3'd1,
      OP_UP     = 3'd2,
      OP_DOWN   = 3'd3,
      OP_DIGIT  = 3'd4,
      OP_COMMIT = 3'd5,
      OP_CANCEL = 3'd6
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_COMMIT,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

### hw/rtl/channel_scan_and_keypad_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel scan and keypad select
// Keeps an in-use bitmap of channels in a word memory, the selected channel
// and a keypad entry value, and answers each request with one response.
// ----------------------------------------------------------------------------
// Digit, cancel and no-op requests need no bitmap read, mark and commit read
// one bitmap word, init scans up to NW words and step up to NW + 1 (the start
// word twice), NW = ceil(NUM_CHANNELS / 32), through the single bitmap read
// port that delivers one 32-bit word a cycle. One request is in flight at a
// time; the response register lets the next request enter while a response
// waits. Reset clears the per-word valid bits, so the bitmap reads as empty.
module channel_scan_and_keypad_select #(
   parameter int NUM_CHANNELS = chsk_pkg::NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // chan[10:0], in_use[11], digit[15:12]
   input  logic [2:0]  req_tuser,   // op[2:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // current_channel[10:0], entry_value[21:11],
                                    // retune[22], not_found[23]
);

   localparam int CW   = $clog2(NUM_CHANNELS + 1);
   localparam int NW   = (NUM_CHANNELS + chsk_pkg::WORD_BITS - 1) / chsk_pkg::WORD_BITS;
   localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
   localparam int IXW  = AW + chsk_pkg::BIT_W;
   localparam int CNW  = $clog2(NW + 1);
   localparam int DW   = CW + 5;

   // Request fields.
   logic [chsk_pkg::CH_W-1:0]    req_chan;
   logic                         req_in_use;
   logic [chsk_pkg::DIGIT_W-1:0] req_digit;
   chsk_pkg::op_type             req_op;

   assign req_chan   = req_tdata[10:0];
   assign req_in_use = req_tdata[11];
   assign req_digit  = req_tdata[15:12];
   assign req_op     = chsk_pkg::op_type'(req_tuser);

   // Control and state registers.
   chsk_pkg::state_type state_ff, state_in;
   chsk_pkg::op_type    op_ff, op_in;
   logic [CW-1:0]       cur_sel_ff, cur_sel_in;
   logic [CW-1:0]       entry_ff, entry_in;
   logic                retune_ff, retune_in;
   logic                missing_ff, missing_in;
   logic                mark_bit_ff, mark_bit_in;
   logic [IXW-1:0]      tgt_idx_ff, tgt_idx_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;

   // Bitmap memory and its read and write ports.
   logic [chsk_pkg::WORD_BITS-1:0] mem [NW];
   logic [NW-1:0]                  word_vld_ff;
   logic [chsk_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                           rd_vld_ff;
   logic [AW-1:0]                  rd_addr_ff;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [chsk_pkg::WORD_BITS-1:0] wr_data;

   // Helpers for the datapath.
   logic [chsk_pkg::WORD_BITS-1:0] rd_word;
   logic [chsk_pkg::WORD_BITS-1:0] scan_mask;
   logic [chsk_pkg::WORD_BITS-1:0] scan_hit;
   logic [chsk_pkg::BIT_W-1:0]     start_bit;
   logic [chsk_pkg::BIT_W-1:0]     low_pos;
   logic [chsk_pkg::BIT_W-1:0]     high_pos;
   logic [chsk_pkg::BIT_W-1:0]     hit_pos;
   logic [IXW-1:0]                 hit_idx;
   logic                           scan_up;
   logic                           scan_last;
   logic [CNW-1:0]                 last_cnt;
   logic [AW-1:0]                  next_addr;
   logic [DW-1:0]                  digit_sum;
   logic                           chan_ok;
   logic                           rsp_free;

   // A word that was never written since reset reads as all zero.
   assign rd_word   = rd_vld_ff ? rd_data_ff : '0;
   assign start_bit = tgt_idx_ff[chsk_pkg::BIT_W-1:0];
   assign scan_up   = (op_ff != chsk_pkg::OP_DOWN);
   assign last_cnt  = (op_ff == chsk_pkg::OP_INIT) ? CNW'(NW - 1) : CNW'(NW);
   assign scan_last = (cnt_ff == last_cnt);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // Mask for the word under scan: the start word is seen twice, first for
   // the bits past the current channel and last for the bits up to it.
   always_comb begin
      scan_mask = '1;
      if (op_ff == chsk_pkg::OP_UP) begin
         if (cnt_ff == '0) begin
            scan_mask = ('1 << start_bit) << 1;
         end else if (scan_last) begin
            scan_mask = ~(('1 << start_bit) << 1);
         end
      end else if (op_ff == chsk_pkg::OP_DOWN) begin
         if (cnt_ff == '0) begin
            scan_mask = ~('1 << start_bit);
         end else if (scan_last) begin
            scan_mask = '1 << start_bit;
         end
      end
   end

   assign scan_hit = rd_word & scan_mask;

   // Lowest and highest set bit of the masked word.
   always_comb begin
      low_pos  = '0;
      high_pos = '0;
      for (int i = chsk_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (scan_hit[i]) begin
            low_pos = chsk_pkg::BIT_W'(i);
         end
      end
      for (int i = 0; i < chsk_pkg::WORD_BITS; i++) begin
         if (scan_hit[i]) begin
            high_pos = chsk_pkg::BIT_W'(i);
         end
      end
   end

   assign hit_pos = scan_up ? low_pos : high_pos;
   assign hit_idx = {rd_addr_ff, hit_pos};

   // Next word address, wrapping at both ends of the bitmap.
   always_comb begin
      if (scan_up) begin
         next_addr = (rd_addr_ff == AW'(NW - 1)) ? '0 : rd_addr_ff + AW'(1);
      end else begin
         next_addr = (rd_addr_ff == '0) ? AW'(NW - 1) : rd_addr_ff - AW'(1);
      end
   end

   // Keypad accumulate: entry times ten plus the digit.
   assign digit_sum = DW'(entry_ff) * DW'(chsk_pkg::DIGIT_BASE) + DW'(req_digit);
   assign chan_ok   = (req_chan != '0) && (32'(req_chan) <= 32'(NUM_CHANNELS));

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_sel_in   = cur_sel_ff;
      entry_in     = entry_ff;
      retune_in    = retune_ff;
      missing_in   = missing_ff;
      mark_bit_in  = mark_bit_ff;
      tgt_idx_in   = tgt_idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = next_addr;
      wr_en        = 1'b0;
      wr_addr      = tgt_idx_ff[IXW-1:chsk_pkg::BIT_W];
      wr_data      = rd_word;
      wr_data[start_bit] = mark_bit_ff;

      unique case (state_ff)
         chsk_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = req_op;
               retune_in   = 1'b0;
               missing_in  = 1'b0;
               mark_bit_in = req_in_use;
               cnt_in      = '0;
               state_in    = chsk_pkg::ST_FINISH;
               unique case (req_op)
                  chsk_pkg::OP_MARK: begin
                     tgt_idx_in = IXW'(req_chan - chsk_pkg::CH_W'(1));
                     if (chan_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = tgt_idx_in[IXW-1:chsk_pkg::BIT_W];
                        state_in = chsk_pkg::ST_MARK;
                     end
                  end
                  chsk_pkg::OP_INIT: begin
                     tgt_idx_in = '0;
                     rd_en      = 1'b1;
                     rd_addr    = '0;
                     state_in   = chsk_pkg::ST_SCAN;
                  end
                  chsk_pkg::OP_UP, chsk_pkg::OP_DOWN: begin
                     tgt_idx_in = IXW'(cur_sel_ff - CW'(1));
                     if (cur_sel_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = tgt_idx_in[IXW-1:chsk_pkg::BIT_W];
                        state_in = chsk_pkg::ST_SCAN;
                     end
                  end
                  chsk_pkg::OP_DIGIT: begin
                     if (32'(req_digit) <= 32'(chsk_pkg::DIGIT_MAX)) begin
                        entry_in = (digit_sum > DW'(NUM_CHANNELS)) ? '0 : CW'(digit_sum);
                     end
                  end
                  chsk_pkg::OP_COMMIT: begin
                     tgt_idx_in = IXW'(entry_ff - CW'(1));
                     if (entry_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = tgt_idx_in[IXW-1:chsk_pkg::BIT_W];
                        state_in = chsk_pkg::ST_COMMIT;
                     end
                  end
                  chsk_pkg::OP_CANCEL: begin
                     entry_in = '0;
                  end
                  default: begin
                     // Unused code: report the state unchanged.
                  end
               endcase
            end
         end

         chsk_pkg::ST_MARK: begin
            // Write back the word with the one bit replaced.
            wr_en    = 1'b1;
            state_in = chsk_pkg::ST_FINISH;
         end

         chsk_pkg::ST_COMMIT: begin
            if (rd_word[start_bit]) begin
               cur_sel_in = entry_ff;
               retune_in  = 1'b1;
            end else begin
               missing_in = 1'b1;
            end
            entry_in = '0;
            state_in = chsk_pkg::ST_FINISH;
         end

         chsk_pkg::ST_SCAN: begin
            // One word per cycle; the next read is issued while this one
            // is examined.
            rd_en  = 1'b1;
            cnt_in = cnt_ff + CNW'(1);
            if (scan_hit != '0) begin
               cur_sel_in = CW'(hit_idx) + CW'(1);
               retune_in  = (op_ff != chsk_pkg::OP_INIT);
               state_in   = chsk_pkg::ST_FINISH;
            end else if (scan_last) begin
               missing_in = 1'b1;
               if (op_ff == chsk_pkg::OP_INIT) begin
                  cur_sel_in = '0;
               end
               state_in = chsk_pkg::ST_FINISH;
            end
         end

         chsk_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {missing_ff, retune_ff,
                               chsk_pkg::CH_W'(entry_ff), chsk_pkg::CH_W'(cur_sel_ff)};
               state_in     = chsk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = chsk_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chsk_pkg::ST_IDLE;
         cur_sel_ff   <= '0;
         entry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         word_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_sel_ff   <= cur_sel_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            word_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      retune_ff   <= retune_in;
      missing_ff  <= missing_in;
      mark_bit_ff <= mark_bit_in;
      tgt_idx_ff  <= tgt_idx_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Bitmap memory: one registered read port and one write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= word_vld_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the controller.
   assert property (@(posedge clock) disable iff (reset)
      cur_sel_ff <= CW'(NUM_CHANNELS))
      else $error("Selected channel beyond the channel count.");

   assert property (@(posedge clock) disable iff (reset)
      entry_ff <= CW'(NUM_CHANNELS))
      else $error("Keypad entry beyond the channel count.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[22] && rsp_tdata[23]))
      else $error("Response flags both retune and not found.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == chsk_pkg::ST_FINISH && rsp_free) |=> rsp_tvalid)
      else $error("Finished transaction did not reach the response register.");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == chsk_pkg::ST_MARK && !req_tready))
      else $error("Bitmap written outside a mark transaction.");

endmodule
